FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pses_pkg.sv
// ----------------------------------------------------------------------------
// Stimulus scheduler package
// Shared widths, queue entry and chain command types, saturating time add.
// ----------------------------------------------------------------------------
`default_nettype none

package pses_pkg;

  localparam int EVENT_SLOTS = 16;
  localparam int TIME_W      = 32;
  localparam int LEVEL_W     = 24;
  localparam int REPEAT_W    = 16;
  localparam int S_TDATA_W   = 168;
  localparam int M_TDATA_W   = 64;

  localparam logic [TIME_W-1:0] END_TIME_RESET = 32'd1000000;

  localparam logic ACTION_LOAD    = 1'b0;
  localparam logic ACTION_ADVANCE = 1'b1;

  typedef logic [TIME_W-1:0] tstamp_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    tstamp_t                   start;
    tstamp_t                   duration;
    tstamp_t                   period;
    logic [REPEAT_W-1:0]       repeats;
  } entry_t;

  typedef struct packed {
    logic   pop;
    logic   ins;
    entry_t ins_entry;
  } chain_op_t;

  function automatic tstamp_t sat_add(tstamp_t a, tstamp_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/periodic_stimulus_event_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic stimulus event scheduler
// Start-ordered stimulus event queue with periodic rescheduling.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one transaction per item: s_tuser selects load (0) or
//   advance (1); s_tdata holds the time and event fields. m_* returns one
//   result transaction per item: level, next break, changed, status.
//   cfg_wr_en/cfg_wr_data write end_time; write only while the block is idle.
// Timing:
//   A load or a plain advance is accepted, passes through ST_FIN and then
//   goes into the m_* output register. An advance that reschedules a
//   periodic event pops the head out of the cell chain in its accept cycle
//   and re-inserts it in ST_INS before ST_FIN, since the chain performs one
//   shift operation per cycle. One item is in work at a time; the next is
//   accepted as soon as the result sits in the output register.
// Reset:
//   Queue empty, no event active, level 0, end_time 1000000.
// Back-pressure:
//   While m_tready is low the result is held; a following item is accepted
//   and worked on, then waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module periodic_stimulus_event_scheduler (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // now_time, event_level, event_start, event_duration, event_period,
  // event_repeats
  input  wire  [pses_pkg::S_TDATA_W-1:0]     s_tdata,
  // action
  input  wire                                s_tuser,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // stimulus_level, next_break, changed, status, zero fill
  output logic [pses_pkg::M_TDATA_W-1:0]     m_tdata,
  input  wire                                cfg_wr_en,
  input  wire  [pses_pkg::TIME_W-1:0]        cfg_wr_data
);
  import pses_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_INS, ST_FIN} state_t;

  state_t                    state;
  tstamp_t                   end_time;
  logic                      active;
  logic signed [LEVEL_W-1:0] active_level;
  tstamp_t                   active_end;
  logic                      changed;
  logic                      status;
  entry_t                    reins_entry;

  tstamp_t   now_time;
  entry_t    in_entry;
  entry_t    head;
  logic      head_valid;
  logic      full;
  chain_op_t op;
  logic      accept;
  logic      stop;
  logic      due;
  logic      reins;
  logic      out_load;
  tstamp_t   brk;
  logic signed [LEVEL_W-1:0] out_level;

  assign now_time         = s_tdata[31:0];
  assign in_entry.level   = s_tdata[55:32];
  assign in_entry.start   = s_tdata[87:56];
  assign in_entry.duration = s_tdata[119:88];
  assign in_entry.period  = s_tdata[151:120];
  assign in_entry.repeats = s_tdata[167:152];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == ST_FIN) && (!m_tvalid || m_tready);

  assign stop  = active && (now_time >= active_end);
  assign due   = head_valid && (now_time >= head.start);
  assign reins = due && (head.period != '0) && (head.repeats != REPEAT_W'(1));

  always_comb begin
    op.pop       = accept && (s_tuser == ACTION_ADVANCE) && due;
    op.ins       = (accept && (s_tuser == ACTION_LOAD) && !full) || (state == ST_INS);
    op.ins_entry = (state == ST_INS) ? reins_entry : in_entry;
  end

  pses_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .head      (head),
    .head_valid(head_valid),
    .full      (full)
  );

  always_comb begin
    brk = end_time;
    if (active && (active_end < brk)) begin
      brk = active_end;
    end
    if (head_valid && (head.start < brk)) begin
      brk = head.start;
    end
    out_level = active ? active_level : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_time <= END_TIME_RESET;
    end else if (cfg_wr_en) begin
      end_time <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active       <= 1'b0;
      active_level <= '0;
      active_end   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (out_load) begin
        m_tdata  <= {(M_TDATA_W-LEVEL_W-TIME_W-2)'(0), status, changed, brk,
                     out_level};
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == ACTION_LOAD) begin
              status  <= full;
              changed <= 1'b0;
              state   <= ST_FIN;
            end else begin
              status  <= 1'b0;
              changed <= stop || due;
              if (due) begin
                active       <= 1'b1;
                active_level <= head.level;
                active_end   <= sat_add(head.start, head.duration);
              end else if (stop) begin
                active       <= 1'b0;
                active_level <= '0;
              end
              reins_entry.level    <= head.level;
              reins_entry.start    <= sat_add(head.start, head.period);
              reins_entry.duration <= head.duration;
              reins_entry.period   <= head.period;
              reins_entry.repeats  <= (head.repeats > REPEAT_W'(1)) ?
                                      head.repeats - REPEAT_W'(1) : head.repeats;
              state <= reins ? ST_INS : ST_FIN;
            end
          end
        end
        ST_INS: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_reins_room, clk, rst, state == ST_INS, !full,
                  "no room to reschedule event")
  `ASSERT_IMPLIES(a_idle_level, clk, rst, !active, active_level == '0,
                  "level held with no active event")
  `ASSERT_NEXT(a_load_quiet, clk, rst, accept && (s_tuser == ACTION_LOAD),
               !changed, "load flagged a change")

endmodule

`default_nettype wire

FILE: hw/rtl/pses_cell.sv
// ----------------------------------------------------------------------------
// Scheduler queue cell
// One queue slot: shifts left on pop, shifts right or captures on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module pses_cell (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 head_cell,
  input  pses_pkg::chain_op_t op,
  input  pses_pkg::entry_t    left_entry,
  input  wire                 left_valid,
  input  pses_pkg::entry_t    right_entry,
  input  wire                 right_valid,
  input  wire                 before_in,
  output pses_pkg::entry_t    entry,
  output logic                valid,
  output logic                before_out
);
  import pses_pkg::*;

  logic claim;

  // head takes equal starts in front, later cells keep equal starts ahead
  assign claim = op.ins && (!valid ||
                 (head_cell ? (entry.start >= op.ins_entry.start)
                            : (entry.start >  op.ins_entry.start)));
  assign before_out = before_in || claim;

  always_ff @(posedge clk) begin
    if (op.pop) begin
      entry <= right_entry;
    end else if (op.ins && before_in) begin
      entry <= left_entry;
    end else if (claim) begin
      entry <= op.ins_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.pop) begin
      valid <= right_valid;
    end else if (op.ins && before_in) begin
      valid <= left_valid;
    end else if (claim) begin
      valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pses_chain.sv
// ----------------------------------------------------------------------------
// Scheduler queue chain
// Row of queue cells holding the start-ordered event queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pses_chain (
  input  wire                 clk,
  input  wire                 rst,
  input  pses_pkg::chain_op_t op,
  output pses_pkg::entry_t    head,
  output logic                head_valid,
  output logic                full
);
  import pses_pkg::*;

  entry_t entry_q [EVENT_SLOTS];
  logic   valid_q [EVENT_SLOTS];
  logic   ahead   [EVENT_SLOTS+1];

  assign ahead[0] = 1'b0;

  for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_v, right_v;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_v = 1'b0;
    end else begin : g_mid_l
      assign left_e = entry_q[i-1];
      assign left_v = valid_q[i-1];
    end

    if (i == EVENT_SLOTS-1) begin : g_last
      assign right_e = '0;
      assign right_v = 1'b0;
    end else begin : g_mid_r
      assign right_e = entry_q[i+1];
      assign right_v = valid_q[i+1];
    end

    pses_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .head_cell  (1'(i == 0)),
      .op         (op),
      .left_entry (left_e),
      .left_valid (left_v),
      .right_entry(right_e),
      .right_valid(right_v),
      .before_in  (ahead[i]),
      .entry      (entry_q[i]),
      .valid      (valid_q[i]),
      .before_out (ahead[i+1])
    );
  end

  assign head       = entry_q[0];
  assign head_valid = valid_q[0];
  assign full       = valid_q[EVENT_SLOTS-1];

  `ASSERT_IMPLIES(a_op_excl, clk, rst, op.pop, !op.ins, "pop and insert together")

  for (genvar i = 1; i < EVENT_SLOTS; i++) begin : g_chk
    `ASSERT_IMPLIES(a_contig, clk, rst, valid_q[i], valid_q[i-1], "hole in queue")
    `ASSERT_IMPLIES(a_order, clk, rst, valid_q[i],
                    entry_q[i-1].start <= entry_q[i].start, "queue out of order")
  end

endmodule

`default_nettype wire
